/* rtl/ptrs_pkg.sv */
// Shared constants and codes for the periodic task release scheduler.
package ptrs_pkg;

    localparam int NUM_SLOTS   = 8;
    localparam int MAX_RESULTS = 8;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_CREATE  = 3'd1;
    localparam logic [2:0] MODE_SUSPEND = 3'd2;
    localparam logic [2:0] MODE_RESUME  = 3'd3;
    localparam logic [2:0] MODE_DELETE  = 3'd4;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef logic [15:0] period_t;

endpackage

/* rtl/periodic_task_release_scheduler.sv */
// Top level of the periodic task release scheduler: slot table, modulo sequencer, output register.
//
// Usage
//   Input channel (in_valid / in_stall, fields mode, slot, period) carries one transaction
//   per tick or slot operation. Output channel (out_valid / out_stall, fields kind,
//   task_slot, ok, last) carries results; the last result caused by a transaction has last 1.
//   A slot operation (create, suspend, resume, delete, or an unknown mode) gives a single
//   status result, which sits in the output register in the cycle after it is taken.
//   A tick bumps the 32-bit counter and then walks the slots in order. For every occupied,
//   running slot with a nonzero period, one shared restoring remainder unit divides the
//   counter by the period after a set-up step, one quotient bit a cycle. A release walk
//   over the slots follows; the receiver can hold it up by stalling releases.
//   A tick with no release gives no result. At most MAX_RESULTS releases leave per tick.
//   in_stall is high while a tick is being worked on, and while the output register holds
//   a result that the receiver is stalling. A stalled result holds its value.
//   Reset (rst_n low, asynchronous) empties every slot, zeroes the counter and drops any
//   result not yet taken.
module periodic_task_release_scheduler
    import ptrs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [7:0]  slot,
    input  logic [15:0] period,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  task_slot,
    output logic        ok,
    output logic        last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(NUM_SLOTS - 1);
    localparam logic [7:0]        NUM_SLOTS_B = 8'(NUM_SLOTS);
    localparam logic [CNT_W-1:0]  LAST_CNT    = CNT_W'(MAX_RESULTS - 1);

    // Sequencer and counter
    logic [1:0]           state_reg, state_next;
    logic [31:0]          count_reg, count_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [NUM_SLOTS-1:0] mask_reg, mask_next;
    logic [CNT_W-1:0]     emit_cnt_reg, emit_cnt_next;

    // Shared remainder unit
    logic [31:0] quot_reg, quot_next;
    logic [15:0] rem_reg, rem_next;
    logic [4:0]  bit_reg, bit_next;

    // Slot table
    logic    occ_reg [NUM_SLOTS];
    logic    occ_next [NUM_SLOTS];
    logic    run_reg [NUM_SLOTS];
    logic    run_next [NUM_SLOTS];
    period_t per_reg [NUM_SLOTS];
    period_t per_next [NUM_SLOTS];

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic       kind_reg, kind_next;
    logic [7:0] task_slot_reg, task_slot_next;
    logic       ok_reg, ok_next;
    logic       last_reg, last_next;

    logic              out_free;
    logic              in_accept;
    logic              in_range;
    logic [SLOT_W-1:0] op_idx;
    logic [16:0]       rem_shift;
    logic [16:0]       rem_diff;
    logic [15:0]       rem_step;
    period_t           cur_period;
    logic              eligible;
    logic              higher_set;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign in_range  = slot < NUM_SLOTS_B;
    assign op_idx    = slot[SLOT_W-1:0];

    assign cur_period = per_reg[idx_reg];
    assign eligible   = occ_reg[idx_reg] && run_reg[idx_reg] && (cur_period != 16'd0);

    // One restoring step: bring down the next counter bit, subtract if it fits
    assign rem_shift = {rem_reg, quot_reg[31]};
    assign rem_diff  = rem_shift - {1'b0, cur_period};
    assign rem_step  = (rem_shift >= {1'b0, cur_period}) ? rem_diff[15:0] : rem_shift[15:0];

    always_comb
    begin
        higher_set = 1'b0;
        for (int j = 0; j < NUM_SLOTS; j++)
        begin
            if ((SLOT_W'(j) > idx_reg) && mask_reg[j])
            begin
                higher_set = 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        emit_cnt_next  = emit_cnt_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        bit_next       = bit_reg;
        occ_next       = occ_reg;
        run_next       = run_reg;
        per_next       = per_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_next      = kind_reg;
        task_slot_next = task_slot_reg;
        ok_next        = ok_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (mode == MODE_TICK)
                    begin
                        count_next = count_reg + 32'd1;
                        idx_next   = '0;
                        mask_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_STATUS;
                        task_slot_next = slot;
                        last_next      = 1'b1;
                        ok_next        = 1'b0;
                        if (in_range)
                        begin
                            case (mode)
                                MODE_CREATE:
                                begin
                                    if (!occ_reg[op_idx])
                                    begin
                                        occ_next[op_idx] = 1'b1;
                                        run_next[op_idx] = 1'b1;
                                        per_next[op_idx] = period;
                                        ok_next          = 1'b1;
                                    end
                                end
                                MODE_SUSPEND:
                                begin
                                    run_next[op_idx] = 1'b0;
                                    ok_next          = 1'b1;
                                end
                                MODE_RESUME:
                                begin
                                    run_next[op_idx] = 1'b1;
                                    ok_next          = 1'b1;
                                end
                                MODE_DELETE:
                                begin
                                    occ_next[op_idx] = 1'b0;
                                    run_next[op_idx] = 1'b0;
                                    per_next[op_idx] = 16'd0;
                                    ok_next          = 1'b1;
                                end
                                default:
                                begin
                                    ok_next = 1'b0;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (eligible)
                begin
                    quot_next  = count_reg;
                    rem_next   = 16'd0;
                    bit_next   = 5'd31;
                    state_next = ST_DIV;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    idx_next      = '0;
                    emit_cnt_next = '0;
                    state_next    = ST_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DIV:
            begin
                rem_next  = rem_step;
                quot_next = {quot_reg[30:0], 1'b0};
                bit_next  = bit_reg - 5'd1;
                if (bit_reg == 5'd0)
                begin
                    mask_next[idx_reg] = (rem_step == 16'd0);
                    if (idx_reg == LAST_SLOT)
                    begin
                        idx_next      = '0;
                        emit_cnt_next = '0;
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_EMIT:
            begin
                if (!mask_reg[idx_reg])
                begin
                    if (idx_reg == LAST_SLOT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_RELEASE;
                    task_slot_next = 8'(idx_reg);
                    ok_next        = 1'b1;
                    last_next      = !higher_set || (emit_cnt_reg == LAST_CNT);
                    emit_cnt_next  = emit_cnt_reg + 1'b1;
                    if (!higher_set || (emit_cnt_reg == LAST_CNT) || (idx_reg == LAST_SLOT))
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= 32'd0;
            idx_reg       <= '0;
            mask_reg      <= '0;
            emit_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++)
            begin
                occ_reg[k] <= 1'b0;
                run_reg[k] <= 1'b0;
                per_reg[k] <= 16'd0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            emit_cnt_reg  <= emit_cnt_next;
            out_valid_reg <= out_valid_next;
            occ_reg       <= occ_next;
            run_reg       <= run_next;
            per_reg       <= per_next;
        end
    end

    // Datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        quot_reg      <= quot_next;
        rem_reg       <= rem_next;
        bit_reg       <= bit_next;
        kind_reg      <= kind_next;
        task_slot_reg <= task_slot_next;
        ok_reg        <= ok_next;
        last_reg      <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign task_slot = task_slot_reg;
    assign ok        = ok_reg;
    assign last      = last_reg;

    // The partial remainder always stays below the divisor
    a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (rem_reg < cur_period))
        else $error("remainder not below period");

    // Never more releases per tick than allowed
    a_emit_cap: assert property (@(posedge clk) disable iff (!rst_n)
        emit_cnt_reg <= CNT_W'(MAX_RESULTS))
        else $error("release count above cap");

    // A tick advances the counter by exactly one
    a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (mode == MODE_TICK)) |=> (count_reg == $past(count_reg) + 32'd1))
        else $error("tick did not advance counter");

    // A slot operation yields a status result on the next cycle
    a_op_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (mode != MODE_TICK)) |=>
            (out_valid_reg && (kind_reg == KIND_STATUS) && last_reg))
        else $error("missing status result");

    // A shown release names an in-range slot
    a_release_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (kind_reg == KIND_RELEASE)) |-> (task_slot_reg < NUM_SLOTS_B))
        else $error("release of out-of-range slot");

endmodule
